[rtl/core/shgb_pkg.sv]
// shared types and codes for the structural hashing gate builder
package shgb_pkg;

	typedef enum logic [2:0] {
		OP_NOT = 3'd0,
		OP_AND = 3'd1,
		OP_OR  = 3'd2,
		OP_XOR = 3'd3,
		OP_MUX = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		RK_GATE   = 2'd0,
		RK_RESULT = 2'd1,
		RK_ERROR  = 2'd2
	} rec_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_UNKNOWN = 2'd1,
		ERR_FULL    = 2'd2,
		ERR_IDS     = 2'd3
	} err_t;

	localparam int FIELD_BITS = 14;

	// one output record, field order as on the master side
	typedef struct packed {
		logic                  last_record;
		logic [1:0]            error_code;
		logic [FIELD_BITS-1:0] result_signal;
		logic [FIELD_BITS-1:0] gate_input_three;
		logic [FIELD_BITS-1:0] gate_input_two;
		logic [FIELD_BITS-1:0] gate_input_one;
		logic [FIELD_BITS-1:0] gate_output;
		logic [2:0]            gate_kind;
		logic [1:0]            record_kind;
	} rec_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_NOT_RD,
		ST_NOT_WAIT,
		ST_NOT_DEC,
		ST_NOT_WR2,
		ST_CMP_RD,
		ST_CMP_WAIT,
		ST_BIN_DEC,
		ST_MUX_DEC,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_INSERT,
		ST_EMIT_WAIT
	} state_t;

endpackage

[rtl/core/structural_hashing_gate_builder.sv]
// top level: request decode, complement memory, gate table scan and record output
//
// channel   dir  transfer contents
// s_axis    in   tdata: operation, operand_a, operand_b, operand_c
// m_axis    out  tdata: record fields; tlast: last_record
//
// After reset a clearing pass wipes the complement memory; no request is
// taken meanwhile. A request with an unknown operand is answered in its
// accepting cycle; otherwise the final record is pushed after decode and,
// where needed, a sequential table search comparing the stored gates one at
// a time (a mux that needs a new not and a new gate takes the longest path).
// Records wait in a four deep queue; a new request starts only once the queue
// is empty, so output stalls hold the input.
module structural_hashing_gate_builder
	import shgb_pkg::*;
#(
	parameter int ID_BITS          = 14,
	parameter int GATE_TABLE_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// operation[2:0], operand_a[16:3], operand_b[30:17], operand_c[44:31], zero fill
	input  logic [47:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// record_kind, gate_kind, gate_output, gate_input_one, two, three,
	// result_signal, error_code from bit 0 up, zero fill
	output logic [79:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	localparam int IDW  = ID_BITS;
	localparam int TBW  = $clog2(GATE_TABLE_DEPTH);
	localparam int ENTW = 3 + 4 * IDW;
	localparam logic [IDW:0] ID_LIMIT = {1'b1, {IDW{1'b0}}};
	localparam logic [TBW:0] TAB_FULL = (TBW+1)'(GATE_TABLE_DEPTH);

	// memories
	logic [IDW:0]    cmap [2**IDW];
	logic [ENTW-1:0] gtab [GATE_TABLE_DEPTH];

	state_t st_q, st_d;
	logic [IDW:0] next_id_q;
	logic [TBW:0] used_q;
	logic [TBW:0] scan_q;
	logic [IDW:0] clr_q;

	// current sub-op
	logic [2:0]     sop_q;
	logic [IDW-1:0] x_q, y_q, z_q;   // current sub-op operands
	logic           chain_q;         // not feeds a following bin
	logic [2:0]     chop_q;          // op of the chained bin
	logic [IDW-1:0] chy_q;           // other operand of chained bin
	logic [1:0]     cmpstep_q;       // which complement probe is pending
	logic           ce_q, cs_t_q, cs_e_q;
	logic [IDW-1:0] res_q;
	err_t           err_q;

	// memory ports
	logic           cm_we;
	logic [IDW-1:0] cm_wa, cm_ra;
	logic [IDW:0]   cm_wd, cm_rd_s1;
	logic           gt_we;
	logic [TBW-1:0] gt_wa, gt_ra;
	logic [ENTW-1:0] gt_wd, gt_rd_s1;

	always_ff @(posedge clk) begin
		if (cm_we) cmap[cm_wa] <= cm_wd;
		cm_rd_s1 <= cmap[cm_ra];
		if (gt_we) gtab[gt_wa] <= gt_wd;
		gt_rd_s1 <= gtab[gt_ra];
	end

	// record queue
	logic push, room, fvalid;
	rec_t prec, orec;
	shgb_out_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_rec(prec),
		.has_room(room), .out_valid(fvalid), .out_ready(m_axis_tready), .out_rec(orec)
	);
	assign m_axis_tvalid = fvalid;
	assign m_axis_tlast  = orec.last_record;
	assign m_axis_tdata  = {{(80-77){1'b0}}, orec.error_code, orec.result_signal,
		orec.gate_input_three, orec.gate_input_two, orec.gate_input_one,
		orec.gate_output, orec.gate_kind, orec.record_kind};

	// input decode, full field width checked against the id counter
	logic [2:0]            in_op;
	logic [FIELD_BITS-1:0] in_fa, in_fb, in_fc;
	logic [FIELD_BITS:0]   id_lim_w;
	logic [IDW-1:0]        in_a, in_b, in_c;
	logic                  in_bad;
	assign in_op    = s_axis_tdata[2:0];
	assign in_fa    = s_axis_tdata[3 +: FIELD_BITS];
	assign in_fb    = s_axis_tdata[17 +: FIELD_BITS];
	assign in_fc    = s_axis_tdata[31 +: FIELD_BITS];
	assign in_a     = in_fa[IDW-1:0];
	assign in_b     = in_fb[IDW-1:0];
	assign in_c     = in_fc[IDW-1:0];
	assign id_lim_w = (FIELD_BITS+1)'(next_id_q);
	assign s_axis_tready = st_q == ST_IDLE && room;
	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign in_bad = in_op > OP_MUX || {1'b0, in_fa} >= id_lim_w ||
		(in_op != OP_NOT && {1'b0, in_fb} >= id_lim_w) ||
		(in_op == OP_MUX && {1'b0, in_fc} >= id_lim_w);

	// complement probe result: valid bit, id
	logic cm_hit;
	logic [IDW-1:0] cm_id;
	assign cm_hit = cm_rd_s1[IDW];
	assign cm_id  = cm_rd_s1[IDW-1:0];

	// binary simplification on x_q,y_q with has_comp(y,x)=ce_q
	logic [IDW-1:0] lo, hi;
	assign lo = x_q < y_q ? x_q : y_q;
	assign hi = x_q < y_q ? y_q : x_q;

	// table entry compare
	logic [ENTW-1:0] key;
	assign key = (sop_q == OP_MUX) ? {sop_q, x_q, y_q, z_q, {IDW{1'b0}}}
		: {sop_q, lo, hi, {IDW{1'b0}}, {IDW{1'b0}}};
	logic key_match;
	assign key_match = gt_rd_s1[ENTW-1:IDW] == key[ENTW-1:IDW];

	// binary rule outcome
	logic           bin_done;
	logic [IDW-1:0] bin_res;
	always_comb begin
		bin_done = 1'b1; bin_res = '0;
		case (sop_q)
			OP_AND: begin
				if (x_q == '0 || y_q == '0) bin_res = '0;
				else if (x_q == IDW'(1)) bin_res = y_q;
				else if (y_q == IDW'(1)) bin_res = x_q;
				else if (x_q == y_q) bin_res = x_q;
				else if (ce_q) bin_res = '0;
				else bin_done = 1'b0;
			end
			OP_OR: begin
				if (x_q == IDW'(1) || y_q == IDW'(1)) bin_res = IDW'(1);
				else if (x_q == '0) bin_res = y_q;
				else if (y_q == '0) bin_res = x_q;
				else if (x_q == y_q) bin_res = x_q;
				else if (ce_q) bin_res = IDW'(1);
				else bin_done = 1'b0;
			end
			default: begin
				if (x_q == '0) bin_res = y_q;
				else if (y_q == '0) bin_res = x_q;
				else if (x_q == y_q) bin_res = '0;
				else if (ce_q) bin_res = IDW'(1);
				else bin_done = 1'b0;
			end
		endcase
	end
	logic bin_to_not;
	assign bin_to_not = sop_q == OP_XOR && x_q != '0 && y_q != '0 &&
		(x_q == IDW'(1) || y_q == IDW'(1));

	// mux rule outcome (x=s, y=t, z=e); ce_q = has_comp(e,t)
	logic           mux_done, mux_chain;
	logic [2:0]     mux_op, mux_chop;
	logic [IDW-1:0] mux_x, mux_y, mux_res;
	always_comb begin
		mux_done = 1'b0; mux_chain = 1'b0; mux_op = OP_MUX; mux_chop = OP_AND;
		mux_x = x_q; mux_y = y_q; mux_res = '0;
		if (x_q == IDW'(1)) begin mux_done = 1'b1; mux_res = y_q; end
		else if (x_q == '0) begin mux_done = 1'b1; mux_res = z_q; end
		else if (y_q == z_q) begin mux_done = 1'b1; mux_res = y_q; end
		else if (y_q == IDW'(1)) begin mux_op = OP_OR; mux_y = z_q; end
		else if (y_q == '0) begin
			mux_op = OP_NOT; mux_chain = 1'b1; mux_chop = OP_AND; mux_y = z_q;
		end else if (z_q == IDW'(1)) begin
			mux_op = OP_NOT; mux_chain = 1'b1; mux_chop = OP_OR;
		end else if (z_q == '0) mux_op = OP_AND;
		else if (ce_q) begin mux_op = OP_XOR; mux_y = z_q; end
		else if (y_q == x_q) begin mux_op = OP_OR; mux_y = z_q; end
		else if (cs_t_q) begin mux_op = OP_AND; mux_x = y_q; mux_y = z_q; end
		else if (z_q == x_q) mux_op = OP_AND;
		else if (cs_e_q) begin mux_op = OP_OR; mux_x = z_q; end
	end

	// not gate needs: valid miss and ids left
	logic not_new;
	assign not_new = !cm_hit && next_id_q != ID_LIMIT;

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR; next_id_q <= (IDW+1)'(2); used_q <= '0;
			clr_q <= '0; scan_q <= '0; chain_q <= 1'b0; sop_q <= '0;
			x_q <= '0; y_q <= '0; z_q <= '0; chop_q <= '0;
			chy_q <= '0; cmpstep_q <= '0; ce_q <= 1'b0; cs_t_q <= 1'b0;
			cs_e_q <= 1'b0; res_q <= '0; err_q <= ERR_NONE;
		end else begin
			st_q <= st_d;
			case (st_q)
				ST_CLEAR: clr_q <= clr_q + 1'b1;
				ST_IDLE: if (acc && !in_bad) begin
					sop_q <= in_op; x_q <= in_a; y_q <= in_b; z_q <= in_c;
					chain_q <= 1'b0; cmpstep_q <= '0; err_q <= ERR_NONE;
				end
				ST_CMP_WAIT: begin
					case (cmpstep_q)
						2'd0: ce_q   <= cm_hit && cm_id == (sop_q == OP_MUX ? y_q : x_q);
						2'd1: cs_t_q <= cm_hit && cm_id == y_q;
						2'd2: cs_e_q <= cm_hit && cm_id == z_q;
						default: ;
					endcase
					cmpstep_q <= cmpstep_q + 2'd1;
				end
				ST_NOT_DEC: begin
					if (cm_hit) res_q <= cm_id;
					else if (next_id_q != ID_LIMIT) begin
						res_q <= next_id_q[IDW-1:0];
						next_id_q <= next_id_q + 1'b1;
					end else err_q <= ERR_IDS;
				end
				ST_EMIT_WAIT: ;
				default: ;
			endcase
			// chained bin takes the not result as its first operand
			if (st_q == ST_NOT_DEC && chain_q && !not_new) begin
				chain_q <= 1'b0; sop_q <= chop_q;
				x_q <= cm_id; y_q <= chy_q; cmpstep_q <= '0;
			end
			if (st_q == ST_NOT_WR2 && chain_q) begin
				chain_q <= 1'b0; sop_q <= chop_q;
				x_q <= res_q; y_q <= chy_q; cmpstep_q <= '0;
			end
			if (st_q == ST_BIN_DEC) begin
				// xor with a constant one becomes a not
				if (sop_q == OP_XOR && x_q != '0 && y_q != '0 && x_q == IDW'(1)) begin
					sop_q <= OP_NOT; x_q <= y_q;
				end else if (sop_q == OP_XOR && x_q != '0 && y_q == IDW'(1)) begin
					sop_q <= OP_NOT;
				end else res_q <= bin_res;
			end
			if (st_q == ST_MUX_DEC) begin
				sop_q <= mux_op; x_q <= mux_x; y_q <= mux_y; cmpstep_q <= '0;
				chain_q <= mux_chain; chop_q <= mux_chop; chy_q <= mux_y;
				res_q <= mux_res;
			end
			if (st_q == ST_NOT_RD && x_q == '0) res_q <= IDW'(1);
			if (st_q == ST_NOT_RD && x_q == IDW'(1)) res_q <= '0;
			if (st_q == ST_SCAN_CHK) begin
				if ({1'b0, scan_q} < used_q && key_match) res_q <= gt_rd_s1[IDW-1:0];
				scan_q <= scan_q + 1'b1;
				if (!({1'b0, scan_q} < used_q)) begin
					if (next_id_q == ID_LIMIT) err_q <= ERR_IDS;
					else if (used_q == TAB_FULL) err_q <= ERR_FULL;
				end
			end
			if (st_q == ST_BIN_DEC || st_q == ST_MUX_DEC) scan_q <= '0;
			if (st_q == ST_INSERT) begin
				res_q <= next_id_q[IDW-1:0];
				next_id_q <= next_id_q + 1'b1;
				used_q <= used_q + 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_CLEAR: if (clr_q == ID_LIMIT - 1'b1) st_d = ST_IDLE;
			ST_IDLE: if (acc) begin
				if (in_bad) st_d = ST_IDLE;
				else if (in_op == OP_NOT) st_d = ST_NOT_RD;
				else st_d = ST_CMP_RD;
			end
			ST_NOT_RD: st_d = (x_q == '0 || x_q == IDW'(1)) ? ST_EMIT_WAIT : ST_NOT_WAIT;
			ST_NOT_WAIT: st_d = ST_NOT_DEC;
			ST_NOT_DEC: begin
				if (!cm_hit && next_id_q == ID_LIMIT) st_d = ST_EMIT_WAIT;
				else if (not_new) st_d = ST_NOT_WR2;
				else st_d = chain_q ? ST_CMP_RD : ST_EMIT_WAIT;
			end
			ST_NOT_WR2: st_d = chain_q ? ST_CMP_RD : ST_EMIT_WAIT;
			ST_CMP_RD: st_d = ST_CMP_WAIT;
			ST_CMP_WAIT: begin
				if (sop_q == OP_MUX && cmpstep_q != 2'd2) st_d = ST_CMP_RD;
				else st_d = sop_q == OP_MUX ? ST_MUX_DEC : ST_BIN_DEC;
			end
			ST_BIN_DEC: begin
				if (bin_to_not) st_d = ST_NOT_RD;
				else st_d = bin_done ? ST_EMIT_WAIT : ST_SCAN_RD;
			end
			ST_MUX_DEC: begin
				if (mux_done) st_d = ST_EMIT_WAIT;
				else if (mux_op == OP_NOT) st_d = ST_NOT_RD;
				else if (mux_op == OP_MUX) st_d = ST_SCAN_RD;
				else st_d = ST_CMP_RD;
			end
			ST_SCAN_RD: st_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if ({1'b0, scan_q} < used_q) st_d = key_match ? ST_EMIT_WAIT : ST_SCAN_RD;
				else if (next_id_q == ID_LIMIT || used_q == TAB_FULL) st_d = ST_EMIT_WAIT;
				else st_d = ST_INSERT;
			end
			ST_INSERT: st_d = ST_EMIT_WAIT;
			ST_EMIT_WAIT: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	// memory and record outputs
	always_comb begin
		cm_we = 1'b0; cm_wa = '0; cm_wd = '0; cm_ra = x_q;
		gt_we = 1'b0; gt_wa = used_q[TBW-1:0]; gt_wd = {key[ENTW-1:IDW], next_id_q[IDW-1:0]};
		gt_ra = scan_q[TBW-1:0];
		push = 1'b0; prec = '0;
		case (st_q)
			ST_CLEAR: begin cm_we = 1'b1; cm_wa = clr_q[IDW-1:0]; end
			ST_IDLE: if (acc && in_bad) begin
				push = 1'b1; prec.record_kind = RK_ERROR;
				prec.error_code = ERR_UNKNOWN; prec.last_record = 1'b1;
			end
			ST_CMP_RD: begin
				case (cmpstep_q)
					2'd0: cm_ra = y_q;
					2'd1: cm_ra = x_q;
					default: cm_ra = x_q;
				endcase
				if (sop_q == OP_MUX && cmpstep_q == 2'd0) cm_ra = z_q;
			end
			ST_NOT_DEC: if (not_new) begin
				cm_we = 1'b1; cm_wa = x_q; cm_wd = {1'b1, next_id_q[IDW-1:0]};
				push = 1'b1; prec.record_kind = RK_GATE; prec.gate_kind = OP_NOT;
				prec.gate_output = next_id_q[IDW-1:0]; prec.gate_input_one = x_q;
			end
			ST_NOT_WR2: begin
				cm_we = 1'b1; cm_wa = res_q; cm_wd = {1'b1, x_q};
			end
			ST_INSERT: begin
				gt_we = 1'b1;
				push = 1'b1; prec.record_kind = RK_GATE; prec.gate_kind = sop_q;
				prec.gate_output = next_id_q[IDW-1:0]; prec.gate_input_one = x_q;
				prec.gate_input_two = sop_q == OP_MUX ? z_q : y_q;
				prec.gate_input_three = sop_q == OP_MUX ? y_q : '0;
			end
			ST_EMIT_WAIT: begin
				push = 1'b1; prec.last_record = 1'b1;
				if (err_q != ERR_NONE) begin
					prec.record_kind = RK_ERROR; prec.error_code = err_q;
				end else begin
					prec.record_kind = RK_RESULT; prec.result_signal = res_q;
				end
			end
			default: ;
		endcase
	end

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> st_q == ST_IDLE) else $error("ready outside idle");
	a_ids_bound: assert property (@(posedge clk) disable iff (!arst_n)
		next_id_q <= ID_LIMIT) else $error("id counter overran");
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= TAB_FULL) else $error("table count overran");
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_INSERT |-> used_q != TAB_FULL) else $error("insert into full table");
endmodule

[rtl/core/shgb_out_fifo.sv]
// record queue between the builder and the master port
module shgb_out_fifo
	import shgb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic has_room,
	output logic out_valid,
	input  logic out_ready,
	output rec_t out_rec
);
	rec_t       mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = cnt_q != 3'd0;
	assign out_rec   = mem_q[rp_q];
	assign has_room  = cnt_q == 3'd0;

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_rec;
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && cnt_q == 3'd4 && !pop)) else $error("record queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4) else $error("record queue count out of range");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 3'd0) else $error("pop from empty queue");
endmodule

[tb/structural_hashing_gate_builder_test.sv]
// testbench for the structural hashing gate builder: scoreboard, drivers and checks
`timescale 1ns / 100ps

import shgb_pkg::*;

// scoreboard: own model of the gate builder and the queue of pending records
class gate_builder_scoreboard;
	localparam int ID_LIMIT = 1 << FIELD_BITS;
	localparam int TABLE_DEPTH = 4096;

	int unsigned next_id;
	int unsigned comp_of [int unsigned];
	bit [2:0] tab_kind [$];
	int unsigned tab_k0 [$], tab_k1 [$], tab_k2 [$], tab_id [$];
	rec_t pending_records [$];
	rec_t new_records [$];
	err_t fail;
	int mismatches;

	function new();
		next_id = 2;
		mismatches = 0;
	endfunction

	function void push_rec(rec_kind_t rk, bit [2:0] gk, int unsigned go, int unsigned i1,
			int unsigned i2, int unsigned i3, int unsigned res, err_t err, bit last);
		rec_t r;
		if (new_records.size() >= 3)
			return;
		r.record_kind = rk;
		r.gate_kind = gk;
		r.gate_output = FIELD_BITS'(go);
		r.gate_input_one = FIELD_BITS'(i1);
		r.gate_input_two = FIELD_BITS'(i2);
		r.gate_input_three = FIELD_BITS'(i3);
		r.result_signal = FIELD_BITS'(res);
		r.error_code = err;
		r.last_record = last;
		new_records.push_back(r);
	endfunction

	function bit is_comp(int unsigned x, int unsigned y);
		return comp_of.exists(x) && comp_of[x] == y;
	endfunction

	function bit build_not(int unsigned a, output int unsigned r);
		int unsigned n;
		if (a == 0) begin r = 1; return 1; end
		if (a == 1) begin r = 0; return 1; end
		if (comp_of.exists(a)) begin r = comp_of[a]; return 1; end
		if (next_id >= ID_LIMIT) begin fail = ERR_IDS; return 0; end
		n = next_id++;
		comp_of[a] = n;
		comp_of[n] = a;
		push_rec(RK_GATE, OP_NOT, n, a, 0, 0, 0, ERR_NONE, 0);
		r = n;
		return 1;
	endfunction

	function bit find_or_add(op_t kind, int unsigned k0, int unsigned k1, int unsigned k2,
			int unsigned i1, int unsigned i2, int unsigned i3, output int unsigned r);
		int unsigned n;
		foreach (tab_kind[i])
			if (tab_kind[i] == kind && tab_k0[i] == k0 && tab_k1[i] == k1 && tab_k2[i] == k2) begin
				r = tab_id[i];
				return 1;
			end
		if (next_id >= ID_LIMIT) begin fail = ERR_IDS; return 0; end
		if (tab_kind.size() >= TABLE_DEPTH) begin fail = ERR_FULL; return 0; end
		n = next_id++;
		tab_kind.push_back(kind);
		tab_k0.push_back(k0);
		tab_k1.push_back(k1);
		tab_k2.push_back(k2);
		tab_id.push_back(n);
		push_rec(RK_GATE, kind, n, i1, i2, i3, 0, ERR_NONE, 0);
		r = n;
		return 1;
	endfunction

	function bit build_two_input(op_t op, int unsigned a, int unsigned b, output int unsigned r);
		int unsigned lo, hi;
		lo = a < b ? a : b;
		hi = a < b ? b : a;
		if (op == OP_AND) begin
			if (a == 0 || b == 0) begin r = 0; return 1; end
			if (a == 1) begin r = b; return 1; end
			if (b == 1) begin r = a; return 1; end
			if (a == b) begin r = a; return 1; end
			if (is_comp(b, a)) begin r = 0; return 1; end
		end else if (op == OP_OR) begin
			if (a == 1 || b == 1) begin r = 1; return 1; end
			if (a == 0) begin r = b; return 1; end
			if (b == 0) begin r = a; return 1; end
			if (a == b) begin r = a; return 1; end
			if (is_comp(b, a)) begin r = 1; return 1; end
		end else begin
			if (a == 0) begin r = b; return 1; end
			if (b == 0) begin r = a; return 1; end
			if (a == 1) return build_not(b, r);
			if (b == 1) return build_not(a, r);
			if (a == b) begin r = 0; return 1; end
			if (is_comp(b, a)) begin r = 1; return 1; end
		end
		return find_or_add(op, lo, hi, 0, a, b, 0, r);
	endfunction

	function bit build_mux(int unsigned s, int unsigned t, int unsigned e, output int unsigned r);
		int unsigned ns;
		if (s == 1) begin r = t; return 1; end
		if (s == 0) begin r = e; return 1; end
		if (t == e) begin r = t; return 1; end
		if (t == 1) return build_two_input(OP_OR, s, e, r);
		if (t == 0) return build_not(s, ns) && build_two_input(OP_AND, ns, e, r);
		if (e == 1) return build_not(s, ns) && build_two_input(OP_OR, ns, t, r);
		if (e == 0) return build_two_input(OP_AND, s, t, r);
		if (is_comp(e, t)) return build_two_input(OP_XOR, s, e, r);
		if (t == s) return build_two_input(OP_OR, s, e, r);
		if (is_comp(s, t)) return build_two_input(OP_AND, t, e, r);
		if (e == s) return build_two_input(OP_AND, s, t, r);
		if (is_comp(s, e)) return build_two_input(OP_OR, e, t, r);
		return find_or_add(OP_MUX, s, t, e, s, e, t, r);
	endfunction

	// accepted request: work out its records
	function void note_request(bit [2:0] op, bit [13:0] a, bit [13:0] b, bit [13:0] c);
		int unsigned r;
		bit ok;
		new_records.delete();
		fail = ERR_NONE;
		r = 0;
		if (op > OP_MUX || a >= next_id || (op != OP_NOT && b >= next_id) ||
				(op == OP_MUX && c >= next_id)) begin
			push_rec(RK_ERROR, 0, 0, 0, 0, 0, 0, ERR_UNKNOWN, 1);
		end else begin
			if (op == OP_NOT)
				ok = build_not(a, r);
			else if (op == OP_MUX)
				ok = build_mux(a, b, c, r);
			else
				ok = build_two_input(op_t'(op), a, b, r);
			if (ok)
				push_rec(RK_RESULT, 0, 0, 0, 0, 0, r, ERR_NONE, 1);
			else
				push_rec(RK_ERROR, 0, 0, 0, 0, 0, 0, fail, 1);
		end
		foreach (new_records[i])
			pending_records.push_back(new_records[i]);
	endfunction

	task report(string what, int unsigned got, int unsigned want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// accepted record: compare with the oldest expectation
	task check_record(logic [79:0] data, logic last);
		rec_t got, want;
		got = {last, data[$bits(rec_t)-2:0]};
		if (data[79:$bits(rec_t)-1] != 0)
			report("zero fill", data[79:$bits(rec_t)-1], 0);
		if (pending_records.size() == 0) begin
			report("unexpected record", got.record_kind, 0);
			return;
		end
		want = pending_records.pop_front();
		if (got.record_kind !== want.record_kind)
			report("record_kind", got.record_kind, want.record_kind);
		if (got.gate_kind !== want.gate_kind)
			report("gate_kind", got.gate_kind, want.gate_kind);
		if (got.gate_output !== want.gate_output)
			report("gate_output", got.gate_output, want.gate_output);
		if (got.gate_input_one !== want.gate_input_one)
			report("gate_input_one", got.gate_input_one, want.gate_input_one);
		if (got.gate_input_two !== want.gate_input_two)
			report("gate_input_two", got.gate_input_two, want.gate_input_two);
		if (got.gate_input_three !== want.gate_input_three)
			report("gate_input_three", got.gate_input_three, want.gate_input_three);
		if (got.result_signal !== want.result_signal)
			report("result_signal", got.result_signal, want.result_signal);
		if (got.error_code !== want.error_code)
			report("error_code", got.error_code, want.error_code);
		if (got.last_record !== want.last_record)
			report("last_record", got.last_record, want.last_record);
	endtask
endclass

module structural_hashing_gate_builder_test;
	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	// operation, operand_a, operand_b, operand_c, zero fill
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// record_kind, gate_kind, gate_output, gate_input_one, two, three,
	// result_signal, error_code, zero fill
	logic [79:0] m_axis_tdata;
	logic        m_axis_tlast;

	gate_builder_scoreboard board;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_output;
	int requests_sent;

	structural_hashing_gate_builder DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

	// 4 ns clock
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// send one request, with random idle cycles before it
	task send_request(bit [2:0] op, bit [13:0] a, bit [13:0] b, bit [13:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b0, c, b, a, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.note_request(op, a, b, c);
		requests_sent++;
		@(negedge clk);
	endtask

	// id weighted toward ones that exist, sometimes constants or unknown
	function bit [13:0] pick_id();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 10)
			return 14'($urandom_range(1));
		if (sel < 14)
			return 14'($urandom());
		if (sel < 18)
			return 14'(board.next_id);
		return 14'($urandom_range(board.next_id - 1));
	endfunction

	task random_requests(int count);
		bit [2:0] op;
		repeat (count) begin
			op = ($urandom_range(49) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
			send_request(op, pick_id(), pick_id(), pick_id());
		end
	endtask

	task wait_drained();
		s_axis_tvalid <= 1'b0;
		while (board.pending_records.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// receiver: random stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (!arst_n || hold_output)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_record(m_axis_tdata, m_axis_tlast);

	// long output hold-off while requests keep being offered
	initial begin
		hold_output = 1'b0;
		wait (requests_sent == 30);
		@(negedge clk);
		hold_output = 1'b1;
		repeat (300) @(negedge clk);
		hold_output = 1'b0;
	end

	initial begin
		board = new();
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		send_idle_pct = 17;
		recv_idle_pct = 85;
		requests_sent = 0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: constants, unknown ids, every operation, simplifications
		send_request(OP_AND, 0, 1, 0);
		send_request(OP_OR, 1, 0, 0);
		send_request(OP_XOR, 1, 1, 0);
		send_request(OP_NOT, 2, 0, 0);
		send_request(OP_NOT, 0, 16383, 16383);
		send_request(OP_NOT, 1, 0, 0);
		send_request(OP_MUX, 0, 1, 0);
		send_request(OP_MUX, 16383, 0, 0);
		send_request(3'd7, 0, 0, 0);
		send_request(3'd5, 1, 1, 1);
		send_request(OP_XOR, 1, 2, 0);
		send_request(OP_XOR, 2, 1, 0);
		send_request(OP_XOR, 2, 1, 0);
		send_request(OP_MUX, 3, 0, 1);
		send_request(OP_MUX, 3, 1, 0);
		send_request(OP_AND, 2, 3, 0);
		send_request(OP_AND, 3, 2, 0);
		send_request(OP_OR, 2, 3, 0);
		send_request(OP_MUX, 3, 1, 1);
		send_request(OP_AND, 4, 3, 0);
		send_request(OP_OR, 4, 3, 0);
		send_request(OP_XOR, 4, 3, 0);
		send_request(OP_MUX, 3, 4, 2);
		send_request(OP_MUX, 2, 0, 3);
		send_request(OP_AND, 5, 3, 0);

		random_requests(60);
		wait_drained();
		send_idle_pct = 85;
		recv_idle_pct = 17;
		random_requests(60);
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_requests(65);
		wait_drained();

		if (board.mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// overall limit
	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
